>>> rtl/ntc_pkg.sv
// Package: shared widths, constants and register indexes for the NTC converter.
package ntc_pkg;

    // Fixed-point fraction bits of the logarithms
    localparam int FRAC_BITS = 24;

    // Operand and log widths (integer part of a 20-bit log2 is at most 19)
    localparam int OPND_W = 20;
    localparam int K_W    = 5;
    localparam int MANT_W = 32;
    localparam int LOG_W  = K_W + FRAC_BITS;
    localparam int SUM_W  = LOG_W + 1;
    localparam int LQ_W   = SUM_W + 1;

    // Nominal temperature in kelvin, hundredths, signed
    localparam int T0C_W  = 18;
    localparam int T0B_W  = 35;
    localparam int A_W    = 39;
    localparam int PROD_W = LQ_W + T0C_W;
    localparam int DQ_W   = FRAC_BITS + 26;
    localparam int DEN_W  = DQ_W - 1;

    // Long division
    localparam int NUM_W     = 36;
    localparam int DIV_STEPS = NUM_W + FRAC_BITS + 8;
    localparam int Q_W       = 42;
    localparam int W_W       = Q_W + 1;

    localparam logic [31:0]    LN2_Q32      = 32'd2977044472;
    localparam logic [Q_W-1:0] QUOT_CAP     = Q_W'(64'd1 << 40);
    localparam logic [W_W-1:0] OFFSET_Q8    = W_W'(699264);
    localparam logic [17:0]    KELVIN_CENTI = 18'd27315;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ADC_FULL_SCALE  = 3'd0,
        REG_REF_MILLIVOLTS  = 3'd1,
        REG_SERIES_OHMS     = 3'd2,
        REG_NOMINAL_OHMS    = 3'd3,
        REG_BETA_KELVIN     = 3'd4,
        REG_NOMINAL_CENTI_C = 3'd5
    } cfg_index_t;

endpackage

>>> rtl/ntc_beta_adc_to_deci_celsius.sv
// Top level: pipelined NTC thermistor ADC code to deci-degree Celsius converter.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-----------------------------------
//  input    | start, busy                | adc_sample
//  result   | done (one-cycle strobe)    | temp_deci_c, fallback
//  config   | cfg_wr_en, cfg_index       | cfg_wdata
//
// busy is always low: one item can enter every cycle.
// done follows the accepting edge through the capture, clamp, squaring log2, sum, ln 2, divider and rounding
// registers; the restoring divider resolves one quotient bit per stage.
// Reset clears the valid bits and loads the register defaults; no data registers reset.
// The receiver cannot stall, so the pipeline never holds.
module ntc_beta_adc_to_deci_celsius
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [15:0]                         adc_sample,
    output logic                                done,
    output logic signed [15:0]                  temp_deci_c,
    output logic                                fallback,
    input  logic                                cfg_wr_en,
    input  logic [ntc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ntc_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    localparam int F   = ntc_pkg::FRAC_BITS;
    localparam int DVS = ntc_pkg::DIV_STEPS;

    // Configuration registers
    logic [15:0]        adc_full_scale_reg;
    logic [15:0]        ref_millivolts_reg;
    logic [19:0]        series_ohms_reg;
    logic [19:0]        nominal_ohms_reg;
    logic [15:0]        beta_kelvin_reg;
    logic [15:0]        nominal_centi_c_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            adc_full_scale_reg  <= 16'd4095;
            ref_millivolts_reg  <= 16'd3300;
            series_ohms_reg     <= 20'd10000;
            nominal_ohms_reg    <= 20'd10000;
            beta_kelvin_reg     <= 16'd3950;
            nominal_centi_c_reg <= 16'd2500;
        end
        else if (cfg_wr_en)
        begin
            case (ntc_pkg::cfg_index_t'(cfg_index))
                ntc_pkg::REG_ADC_FULL_SCALE:  adc_full_scale_reg  <= cfg_wdata[15:0];
                ntc_pkg::REG_REF_MILLIVOLTS:  ref_millivolts_reg  <= cfg_wdata[15:0];
                ntc_pkg::REG_SERIES_OHMS:     series_ohms_reg     <= cfg_wdata;
                ntc_pkg::REG_NOMINAL_OHMS:    nominal_ohms_reg    <= cfg_wdata;
                ntc_pkg::REG_BETA_KELVIN:     beta_kelvin_reg     <= cfg_wdata[15:0];
                ntc_pkg::REG_NOMINAL_CENTI_C: nominal_centi_c_reg <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // Terms that depend on configuration only (the user must keep it stable while items are in flight; not enforced)
    logic                                   cfg_bad;
    logic signed [ntc_pkg::T0C_W-1:0]       t0c;
    logic signed [ntc_pkg::T0B_W-1:0]       t0b_reg;
    logic signed [ntc_pkg::A_W-1:0]         a_val;
    logic [ntc_pkg::NUM_W-1:0]              num_reg;
    logic                                   aneg_reg;
    logic [22:0]                            beta100;
    logic signed [ntc_pkg::DQ_W-1:0]        base_dq;

    assign cfg_bad = (adc_full_scale_reg == 16'd0) || (ref_millivolts_reg == 16'd0) ||
                     (series_ohms_reg == 20'd0) || (nominal_ohms_reg == 20'd0) ||
                     (beta_kelvin_reg == 16'd0);
    assign t0c     = $signed({{2{nominal_centi_c_reg[15]}}, nominal_centi_c_reg})
                     + $signed(ntc_pkg::KELVIN_CENTI);
    assign a_val   = (ntc_pkg::A_W'(t0b_reg) <<< 3) + (ntc_pkg::A_W'(t0b_reg) <<< 1);
    assign beta100 = (23'(beta_kelvin_reg) << 6) + (23'(beta_kelvin_reg) << 5)
                     + (23'(beta_kelvin_reg) << 2);
    assign base_dq = $signed(ntc_pkg::DQ_W'(beta100) << F);

    always_ff @(posedge clk)
    begin
        t0b_reg  <= ntc_pkg::T0B_W'(t0c) * $signed(ntc_pkg::T0B_W'({1'b0, beta_kelvin_reg}));
        num_reg  <= a_val[ntc_pkg::A_W-1] ? ntc_pkg::NUM_W'(-a_val)
                                          : ntc_pkg::NUM_W'(a_val);
        aneg_reg <= a_val[ntc_pkg::A_W-1];
    end

    assign busy = 1'b0;

    // Stage 1: capture the sample
    logic               s1_v_reg;
    logic [15:0]        s1_smp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_v_reg <= 1'b0;
        else
            s1_v_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        s1_smp_reg <= adc_sample;
    end

    // Stage 2: clamp the sample, form the lower leg, check guards
    logic [15:0]                    s_cl;
    logic [15:0]                    s_diff;
    logic                           s2_v_reg;
    logic                           s2_g_reg;
    logic [ntc_pkg::OPND_W-1:0]     s2_op_reg [0:3];

    assign s_cl   = (s1_smp_reg >= adc_full_scale_reg) ? adc_full_scale_reg - 16'd1
                                                       : s1_smp_reg;
    assign s_diff = adc_full_scale_reg - s_cl;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_v_reg <= 1'b0;
        else
            s2_v_reg <= s1_v_reg;
    end

    always_ff @(posedge clk)
    begin
        s2_g_reg     <= cfg_bad || (s_cl == 16'd0);
        s2_op_reg[0] <= series_ohms_reg;
        s2_op_reg[1] <= ntc_pkg::OPND_W'(s_cl);
        s2_op_reg[2] <= ntc_pkg::OPND_W'(s_diff);
        s2_op_reg[3] <= nominal_ohms_reg;
    end

    // Stage 3: normalise each operand; then one squaring per stage for the fraction
    logic                           lg_v_reg [0:F];
    logic                           lg_g_reg [0:F];
    logic [ntc_pkg::K_W-1:0]        lg_k_reg [0:F][0:3];
    logic [ntc_pkg::MANT_W-1:0]     lg_m_reg [0:F][0:3];
    logic [F-1:0]                   lg_f_reg [0:F][0:3];

    function automatic logic [ntc_pkg::K_W-1:0] lead_one(input logic [ntc_pkg::OPND_W-1:0] x);
        logic [ntc_pkg::K_W-1:0] k;
        k = '0;
        for (int b = 1; b < ntc_pkg::OPND_W; b++)
        begin
            if (x[b])
                k = ntc_pkg::K_W'(b);
        end
        return k;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lg_v_reg[0] <= 1'b0;
        else
            lg_v_reg[0] <= s2_v_reg;
    end

    always_ff @(posedge clk)
    begin
        lg_g_reg[0] <= s2_g_reg;
        for (int n = 0; n < 4; n++)
        begin
            lg_k_reg[0][n] <= lead_one(s2_op_reg[n]);
            lg_m_reg[0][n] <= ntc_pkg::MANT_W'(s2_op_reg[n])
                              << (5'd31 - lead_one(s2_op_reg[n]));
            lg_f_reg[0][n] <= '0;
        end
    end

    for (genvar j = 0; j < F; j++)
    begin : g_sq
        logic [63:0]    sq   [0:3];
        logic [32:0]    sq_t [0:3];

        always_comb
        begin
            for (int n = 0; n < 4; n++)
            begin
                sq[n]   = 64'(lg_m_reg[j][n]) * 64'(lg_m_reg[j][n]);
                sq_t[n] = sq[n][63:31];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                lg_v_reg[j+1] <= 1'b0;
            else
                lg_v_reg[j+1] <= lg_v_reg[j];
        end

        always_ff @(posedge clk)
        begin
            lg_g_reg[j+1] <= lg_g_reg[j];
            for (int n = 0; n < 4; n++)
            begin
                lg_k_reg[j+1][n] <= lg_k_reg[j][n];
                lg_m_reg[j+1][n] <= sq_t[n][32] ? sq_t[n][32:1] : sq_t[n][31:0];
                lg_f_reg[j+1][n] <= {lg_f_reg[j][n][F-2:0], sq_t[n][32]};
            end
        end
    end

    // Sum of logs: numerator legs and denominator legs, each summed
    logic                           sm_v_reg;
    logic                           sm_g_reg;
    logic [ntc_pkg::SUM_W-1:0]      pos_reg;
    logic [ntc_pkg::SUM_W-1:0]      neg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sm_v_reg <= 1'b0;
        else
            sm_v_reg <= lg_v_reg[F];
    end

    always_ff @(posedge clk)
    begin
        sm_g_reg <= lg_g_reg[F];
        pos_reg  <= ntc_pkg::SUM_W'({lg_k_reg[F][0], lg_f_reg[F][0]})
                    + ntc_pkg::SUM_W'({lg_k_reg[F][1], lg_f_reg[F][1]});
        neg_reg  <= ntc_pkg::SUM_W'({lg_k_reg[F][2], lg_f_reg[F][2]})
                    + ntc_pkg::SUM_W'({lg_k_reg[F][3], lg_f_reg[F][3]});
    end

    // Sign and magnitude of the log sum
    logic                           mg_v_reg;
    logic                           mg_g_reg;
    logic                           mg_neg_reg;
    logic [ntc_pkg::SUM_W-1:0]      mg_mag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mg_v_reg <= 1'b0;
        else
            mg_v_reg <= sm_v_reg;
    end

    always_ff @(posedge clk)
    begin
        mg_g_reg   <= sm_g_reg;
        mg_neg_reg <= neg_reg > pos_reg;
        mg_mag_reg <= (neg_reg > pos_reg) ? neg_reg - pos_reg : pos_reg - neg_reg;
    end

    // Scale by ln 2 (Q32), truncated
    logic [ntc_pkg::SUM_W+31:0]     ln_prod;
    logic                           ln_v_reg;
    logic                           ln_g_reg;
    logic                           ln_neg_reg;
    logic [ntc_pkg::SUM_W-1:0]      ln_mag_reg;

    assign ln_prod = (ntc_pkg::SUM_W+32)'(mg_mag_reg) * (ntc_pkg::SUM_W+32)'(ntc_pkg::LN2_Q32);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ln_v_reg <= 1'b0;
        else
            ln_v_reg <= mg_v_reg;
    end

    always_ff @(posedge clk)
    begin
        ln_g_reg   <= mg_g_reg;
        ln_neg_reg <= mg_neg_reg;
        ln_mag_reg <= ln_prod[32 +: ntc_pkg::SUM_W];
    end

    // T0 times the signed log ratio
    logic signed [ntc_pkg::LQ_W-1:0]    lq;
    logic                               pr_v_reg;
    logic                               pr_g_reg;
    logic signed [ntc_pkg::PROD_W-1:0]  pr_reg;

    assign lq = ln_neg_reg ? -$signed({1'b0, ln_mag_reg}) : $signed({1'b0, ln_mag_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pr_v_reg <= 1'b0;
        else
            pr_v_reg <= ln_v_reg;
    end

    always_ff @(posedge clk)
    begin
        pr_g_reg <= ln_g_reg;
        pr_reg   <= ntc_pkg::PROD_W'(t0c) * ntc_pkg::PROD_W'(lq);
    end

    // Denominator of the beta equation
    logic                               dq_v_reg;
    logic                               dq_g_reg;
    logic signed [ntc_pkg::DQ_W-1:0]    dq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dq_v_reg <= 1'b0;
        else
            dq_v_reg <= pr_v_reg;
    end

    always_ff @(posedge clk)
    begin
        dq_g_reg <= pr_g_reg;
        dq_reg   <= base_dq + ntc_pkg::DQ_W'(pr_reg);
    end

    // Divider pipeline: stage 0 holds |D| and the quotient sign, one bit per stage after
    logic                           dv_v_reg    [0:DVS];
    logic                           dv_g_reg    [0:DVS];
    logic                           dv_neg_reg  [0:DVS];
    logic                           dv_over_reg [0:DVS];
    logic [ntc_pkg::DEN_W-1:0]      dv_den_reg  [0:DVS];
    logic [ntc_pkg::DEN_W-1:0]      dv_r_reg    [0:DVS];
    logic [ntc_pkg::Q_W-1:0]        dv_q_reg    [0:DVS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_v_reg[0] <= 1'b0;
        else
            dv_v_reg[0] <= dq_v_reg;
    end

    always_ff @(posedge clk)
    begin
        dv_g_reg[0]    <= dq_g_reg;
        dv_neg_reg[0]  <= aneg_reg ^ dq_reg[ntc_pkg::DQ_W-1];
        dv_den_reg[0]  <= dq_reg[ntc_pkg::DQ_W-1] ? ntc_pkg::DEN_W'(-dq_reg)
                                                  : ntc_pkg::DEN_W'(dq_reg);
        dv_r_reg[0]    <= '0;
        dv_q_reg[0]    <= '0;
        dv_over_reg[0] <= 1'b0;
    end

    for (genvar i = 0; i < DVS; i++)
    begin : g_div
        logic                       nbit;
        logic [ntc_pkg::DEN_W:0]    rs;
        logic                       ge;
        logic [ntc_pkg::Q_W-1:0]    q_nx;

        if (i < ntc_pkg::NUM_W)
        begin : g_bit
            assign nbit = num_reg[ntc_pkg::NUM_W-1-i];
        end
        else
        begin : g_zero
            assign nbit = 1'b0;
        end

        assign rs   = {dv_r_reg[i], nbit};
        assign ge   = rs >= {1'b0, dv_den_reg[i]};
        assign q_nx = {dv_q_reg[i][ntc_pkg::Q_W-2:0], ge};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_v_reg[i+1] <= 1'b0;
            else
                dv_v_reg[i+1] <= dv_v_reg[i];
        end

        always_ff @(posedge clk)
        begin
            dv_g_reg[i+1]    <= dv_g_reg[i];
            dv_neg_reg[i+1]  <= dv_neg_reg[i];
            dv_den_reg[i+1]  <= dv_den_reg[i];
            dv_r_reg[i+1]    <= ge ? ntc_pkg::DEN_W'(rs - {1'b0, dv_den_reg[i]})
                                   : ntc_pkg::DEN_W'(rs);
            dv_q_reg[i+1]    <= q_nx;
            // once past the cap the quotient only grows, so the flag is sticky
            dv_over_reg[i+1] <= dv_over_reg[i] || (q_nx > ntc_pkg::QUOT_CAP);
        end
    end

    // Apply the sign and remove the kelvin offset (Q8)
    logic [ntc_pkg::Q_W-1:0]            q_fin;
    logic signed [ntc_pkg::W_W-1:0]     v_fin;
    logic                               wa_v_reg;
    logic                               wa_g_reg;
    logic signed [ntc_pkg::W_W-1:0]     wa_reg;

    assign q_fin = dv_over_reg[DVS] ? ntc_pkg::QUOT_CAP : dv_q_reg[DVS];
    assign v_fin = dv_neg_reg[DVS] ? -$signed({1'b0, q_fin}) : $signed({1'b0, q_fin});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wa_v_reg <= 1'b0;
        else
            wa_v_reg <= dv_v_reg[DVS];
    end

    always_ff @(posedge clk)
    begin
        wa_g_reg <= dv_g_reg[DVS];
        wa_reg   <= v_fin - $signed(ntc_pkg::OFFSET_Q8);
    end

    // Magnitude for rounding half away from zero
    logic                           wb_v_reg;
    logic                           wb_g_reg;
    logic                           wb_neg_reg;
    logic [ntc_pkg::W_W-1:0]        wb_mag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wb_v_reg <= 1'b0;
        else
            wb_v_reg <= wa_v_reg;
    end

    always_ff @(posedge clk)
    begin
        wb_g_reg   <= wa_g_reg;
        wb_neg_reg <= wa_reg[ntc_pkg::W_W-1];
        wb_mag_reg <= wa_reg[ntc_pkg::W_W-1] ? ntc_pkg::W_W'(-wa_reg) : ntc_pkg::W_W'(wa_reg);
    end

    // Round, saturate, force fallback; output registers
    logic [ntc_pkg::W_W-1:0]        rnd;
    logic [15:0]                    res;
    logic                           done_reg;
    logic [15:0]                    temp_reg;
    logic                           fb_reg;

    assign rnd = (wb_mag_reg + ntc_pkg::W_W'(128)) >> 8;

    always_comb
    begin
        if (!wb_neg_reg)
            res = (rnd > ntc_pkg::W_W'(32767)) ? 16'h7FFF : rnd[15:0];
        else
            res = (rnd > ntc_pkg::W_W'(32768)) ? 16'h8000 : 16'(-rnd[15:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= wb_v_reg;
    end

    always_ff @(posedge clk)
    begin
        temp_reg <= wb_g_reg ? 16'd0 : res;
        fb_reg   <= wb_g_reg;
    end

    assign done        = done_reg;
    assign temp_deci_c = $signed(temp_reg);
    assign fallback    = fb_reg;

endmodule
